// ===== sv/ita_pkg.sv =====
// Shared types, character codes and command encodings for the integer to ASCII formatter.
package ita_pkg;

   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned CommandWidth = 2;
   localparam int unsigned CharWidth    = 7;
   localparam int unsigned DigitCount   = 10;
   localparam int unsigned HexCount     = 8;
   localparam int unsigned BcdWidth     = 4 * DigitCount;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned StepWidth    = 5;

   localparam logic [CommandWidth-1:0] CMD_UNSIGNED = 2'd0;
   localparam logic [CommandWidth-1:0] CMD_SIGNED   = 2'd1;
   localparam logic [CommandWidth-1:0] CMD_HEX      = 2'd2;

   localparam logic [CharWidth-1:0] CHAR_ZERO    = 7'd48;
   localparam logic [CharWidth-1:0] CHAR_LOWER_A = 7'd97;
   localparam logic [CharWidth-1:0] CHAR_MINUS   = 7'd45;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic advance;
      logic sel_sign;
   } ita_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hex;
      logic neg;
      logic step_last;
      logic top_zero;
      logic count_one;
   } ita_status_type;

   function automatic logic [CharWidth-1:0] nibble_char(input logic [3:0] nib);
      logic [CharWidth-1:0] result;
      if (nib < 4'd10) begin
         result = CHAR_ZERO + {3'b000, nib};
      end else begin
         result = CHAR_LOWER_A + {3'b000, nib} - 7'd10;
      end
      return result;
   endfunction

endpackage

// ===== sv/ita_if.sv =====
// Request and response channel interfaces of the formatter.
interface ita_req_if import ita_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ValueWidth-1:0]   value;
   logic [CommandWidth-1:0] command;

   modport source (output valid, output value, output command, input ready);
   modport sink   (input valid, input value, input command, output ready);
endinterface

interface ita_rsp_if import ita_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] ascii_char;
   logic                 last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: controller and datapath joined.
//
//   Channel   Direction  Payload
//   req_bus   in         value[31:0], command[1:0]
//   rsp_bus   out        ascii_char[6:0], last
//
// One request is taken at a time, in the idle cycle that also loads it.
// Decimal requests then go through shift-add-3 conversion and hexadecimal requests
// pass straight through the convert state; a negative signed request first emits a minus sign.
// Leading zeros are then suppressed and the remaining characters are output one per
// cycle while rsp_bus.ready is high. A stalled response holds its character; reset
// returns the controller to idle.
module integer_to_ascii_formatter import ita_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ita_req_if.sink     req_bus,
   ita_rsp_if.source   rsp_bus
);

   ita_cmd_type    cmd;
   ita_status_type status;

   ita_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_last  (rsp_bus.last),
      .status    (status),
      .cmd       (cmd)
   );

   ita_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_bus.value),
      .command    (req_bus.command),
      .cmd        (cmd),
      .status     (status),
      .ascii_char (rsp_bus.ascii_char)
   );

endmodule

// ===== sv/ita_datapath.sv =====
// Datapath: shift-add-3 binary to BCD converter and character shift register.
module ita_datapath import ita_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ValueWidth-1:0]   value,
   input  logic [CommandWidth-1:0] command,
   input  ita_cmd_type             cmd,
   output ita_status_type          status,
   output logic [CharWidth-1:0]    ascii_char
);

   logic [ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic                  hex_ff, hex_in;
   logic                  neg_ff, neg_in;
   logic [BcdWidth-1:0]   adjusted;
   logic                  load_neg;

   // Each BCD digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign load_neg = (command == CMD_SIGNED) && value[ValueWidth-1];

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      step_in  = step_ff;
      hex_in   = hex_ff;
      neg_in   = neg_ff;
      if (cmd.load) begin
         hex_in  = command[1];
         neg_in  = load_neg;
         step_in = '0;
         bin_in  = load_neg ? (~value + 32'd1) : value;
         if (command[1]) begin
            bcd_in   = {value, {(BcdWidth-ValueWidth){1'b0}}};
            count_in = CountWidth'(HexCount);
         end else begin
            bcd_in   = '0;
            count_in = CountWidth'(DigitCount);
         end
      end else if (cmd.step) begin
         bcd_in  = {adjusted[BcdWidth-2:0], bin_ff[ValueWidth-1]};
         bin_in  = {bin_ff[ValueWidth-2:0], 1'b0};
         step_in = step_ff + 5'd1;
      end else if (cmd.advance) begin
         bcd_in   = {bcd_ff[BcdWidth-5:0], 4'h0};
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
         hex_ff   <= 1'b0;
         neg_ff   <= 1'b0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
         hex_ff   <= hex_in;
         neg_ff   <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.hex       = hex_ff;
   assign status.neg       = neg_ff;
   assign status.step_last = (step_ff == {StepWidth{1'b1}});
   assign status.top_zero  = (bcd_ff[BcdWidth-1 -: 4] == 4'h0);
   assign status.count_one = (count_ff == 4'd1);

   assign ascii_char = cmd.sel_sign ? CHAR_MINUS : nibble_char(bcd_ff[BcdWidth-1 -: 4]);

endmodule

// ===== sv/ita_control.sv =====
// Controller: sequences conversion, sign, zero suppression and character output.
module ita_control import ita_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_last,
   input  ita_status_type status,
   output ita_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.hex) begin
               state_in = ST_SKIP;
            end else begin
               cmd.step = 1'b1;
               if (status.step_last) begin
                  state_in = status.neg ? ST_SIGN : ST_SKIP;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped, but the final digit always stays.
            if (status.top_zero && !status.count_one) begin
               cmd.advance = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = status.count_one;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.count_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
